[hdl/priority_table_remove_by_priority_macros.svh]
// Assertion macros for the priority table block.
`ifndef PRIORITY_TABLE_REMOVE_BY_PRIORITY_MACROS_SVH
`define PRIORITY_TABLE_REMOVE_BY_PRIORITY_MACROS_SVH

`ifndef NO_ASSERTIONS
// check while out of reset
`define PTRBP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define PTRBP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTRBP_ASSERT(label, clk, rst_n, prop, msg)
`define PTRBP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hdl/ptrbp_pkg.sv]
package ptrbp_pkg;

  localparam int TABLE_DEPTH   = 16;
  localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W       = 32;
  localparam int PRIO_W        = 8;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic                      command;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic                      found;
    logic                      refused;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/ptrbp_ram.sv]
module ptrbp_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 40,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/priority_table_remove_by_priority.sv]
// Bounded priority table: up to TABLE_DEPTH (value, priority) entries.
// Input channel in_valid/in_ready/in_data carries one command per
// transaction: insert (entry goes to the head) or remove (sort the table
// ascending by priority, then delete the first entry with the requested
// priority). Each command yields exactly one result transaction on
// out_valid/out_ready/out_data with the removed value, found/refused flags
// and the entry count after the command.
// Insert: the result is valid the cycle after acceptance.
// Remove on n entries: one exchange-sort compare per cycle through a table
// RAM with one read port, one write port and registered read data, then a
// match scan and gap close. An empty table answers in the cycle after
// acceptance.
// One command is in flight at a time; in_ready is low while a remove runs
// and while a result is held that the receiver has not taken. A stalled
// result stays in the output register unchanged.
// Synchronous reset empties the table (count and head pointer cleared) and
// drops any pending result; no clearing pass is needed.
module priority_table_remove_by_priority (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptrbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptrbp_pkg::out_item_t out_data
);

  import ptrbp_pkg::*;

  `include "priority_table_remove_by_priority_macros.svh"

  localparam int CMP_W = CNT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_I,
    ST_CMP,
    ST_WB,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  entry_t           cur_r, cur_nxt;
  logic [PRIO_W-1:0] target_r, target_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] wr_l;
  logic [CMP_W-1:0] rd_l;
  logic             wr_head;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] rdata_bits;

  logic             in_fire;
  logic             full;
  logic [CMP_W-1:0] count_w;
  logic [CMP_W-1:0] i_inc;
  logic [CMP_W-1:0] j_inc;
  logic [CMP_W-1:0] j_inc2;
  logic [IDX_W-1:0] head_dec;

  // logical slot -> physical RAM address, table kept as a ring from head_r
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                 input logic [CMP_W-1:0] slot);
    logic [CMP_W:0] sum;
    sum = CMP_W'(head) + slot;
    if (sum >= (CMP_W + 1)'(TABLE_DEPTH)) begin
      sum = sum - (CMP_W + 1)'(TABLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign count_w  = CMP_W'(count_r);
  assign i_inc    = CMP_W'(i_r) + 1'b1;
  assign j_inc    = CMP_W'(j_r) + 1'b1;
  assign j_inc2   = CMP_W'(j_r) + 2'd2;
  assign head_dec = (head_r == '0) ? IDX_W'(TABLE_DEPTH - 1) : head_r - 1'b1;

  assign ram_waddr = wr_head ? head_dec : phys_addr(head_r, CMP_W'(wr_l));
  assign ram_raddr = phys_addr(head_r, rd_l);
  assign ram_rdata = entry_t'(rdata_bits);

  ptrbp_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata_bits)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    wr_head       = 1'b0;
    wr_l          = j_r;
    ram_wdata     = cur_r;
    rd_l          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_data_nxt.removed_value = '0;
          out_data_nxt.found         = 1'b0;
          out_data_nxt.refused       = 1'b0;
          out_data_nxt.entry_count   = ENTRY_COUNT_W'(count_r);
          if (in_data.command == CMD_INSERT) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_data_nxt.refused = 1'b1;
            end else begin
              ram_we                   = 1'b1;
              wr_head                  = 1'b1;
              ram_wdata.value          = in_data.item_value;
              ram_wdata.prio           = in_data.item_priority;
              head_nxt                 = head_dec;
              count_nxt                = count_r + 1'b1;
              out_data_nxt.entry_count = ENTRY_COUNT_W'(count_r + 1'b1);
            end
          end else begin
            target_nxt = in_data.item_priority;
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              i_nxt     = '0;
              rd_l      = '0;
              state_nxt = ST_LD_I;
            end
          end
        end
      end

      // slot i is in the read register; start comparing it against later slots
      ST_LD_I: begin
        cur_nxt = ram_rdata;
        if (i_inc < count_w) begin
          j_nxt     = IDX_W'(i_inc);
          rd_l      = i_inc;
          state_nxt = ST_CMP;
        end else begin
          j_nxt     = '0;
          rd_l      = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_CMP: begin
        if (ram_rdata.prio < cur_r.prio) begin
          ram_we    = 1'b1;
          wr_l      = j_r;
          ram_wdata = cur_r;
          cur_nxt   = ram_rdata;
        end
        if (j_inc < count_w) begin
          j_nxt = IDX_W'(j_inc);
          rd_l  = j_inc;
        end else begin
          state_nxt = ST_WB;
        end
      end

      ST_WB: begin
        ram_we    = 1'b1;
        wr_l      = i_r;
        ram_wdata = cur_r;
        i_nxt     = IDX_W'(i_inc);
        rd_l      = i_inc;
        state_nxt = ST_LD_I;
      end

      ST_SCAN: begin
        if (ram_rdata.prio == target_r) begin
          if (j_inc < count_w) begin
            cur_nxt   = ram_rdata;
            rd_l      = j_inc;
            state_nxt = ST_SHIFT;
          end else begin
            count_nxt                  = count_r - 1'b1;
            out_valid_nxt              = 1'b1;
            out_data_nxt.removed_value = ram_rdata.value;
            out_data_nxt.found         = 1'b1;
            out_data_nxt.entry_count   = ENTRY_COUNT_W'(count_r - 1'b1);
            state_nxt                  = ST_IDLE;
          end
        end else if (j_inc < count_w) begin
          j_nxt = IDX_W'(j_inc);
          rd_l  = j_inc;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // close the gap: slot j takes slot j+1
      ST_SHIFT: begin
        ram_we    = 1'b1;
        wr_l      = j_r;
        ram_wdata = ram_rdata;
        if (j_inc2 < count_w) begin
          j_nxt = IDX_W'(j_inc);
          rd_l  = j_inc2;
        end else begin
          count_nxt                  = count_r - 1'b1;
          out_valid_nxt              = 1'b1;
          out_data_nxt.removed_value = cur_r.value;
          out_data_nxt.found         = 1'b1;
          out_data_nxt.entry_count   = ENTRY_COUNT_W'(count_r - 1'b1);
          state_nxt                  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cur_r      <= cur_nxt;
    target_r   <= target_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PTRBP_ASSERT_ALWAYS(a_reset_clears, clk,
    !rst_n |=> (!out_valid_r && state_r == ST_IDLE && count_r == '0), "reset left state")
  `PTRBP_ASSERT(a_count_bound, clk, rst_n,
    count_r <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
  `PTRBP_ASSERT(a_insert_count, clk, rst_n,
    (in_fire && in_data.command == CMD_INSERT && !full) |=> count_r == $past(count_r) + 1'b1,
    "insert did not grow the table")
  `PTRBP_ASSERT(a_cmp_range, clk, rst_n,
    (state_r == ST_CMP) |-> (j_r > i_r && CMP_W'(j_r) < count_w), "sort index out of range")
  `PTRBP_ASSERT(a_flags_exclusive, clk, rst_n,
    out_valid_r |-> !(out_data_r.found && out_data_r.refused), "found and refused together")

endmodule

[sim/priority_table_remove_by_priority_checker.sv]
`timescale 1ns / 100ps

module priority_table_remove_by_priority_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  ptrbp_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  ptrbp_pkg::out_item_t out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   found_seen,
  output int                   refused_seen
);
  import ptrbp_pkg::*;

  localparam int MAX_REPORTS = 10;

  // shadow copy of the table
  logic [VALUE_W-1:0] shadow_val [TABLE_DEPTH];
  logic [PRIO_W-1:0]  shadow_pri [TABLE_DEPTH];
  int                 shadow_fill;

  out_item_t result_q[$];
  int        errs;
  int        hits;
  int        drops;

  // Applies one command to the shadow table and returns the result it yields.
  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t          res;
    int                 i;
    int                 j;
    int                 hit;
    logic [VALUE_W-1:0] tv;
    logic [PRIO_W-1:0]  tp;
    res = '0;
    if (cmd.command == CMD_INSERT) begin
      if (shadow_fill >= TABLE_DEPTH) begin
        res.refused = 1'b1;
      end else begin
        for (i = shadow_fill; i > 0; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_val[0] = cmd.item_value;
        shadow_pri[0] = cmd.item_priority;
        shadow_fill++;
      end
    end else begin
      // exchange sort, strict less-than swaps; order is kept even on a miss
      for (i = 0; i < shadow_fill; i++) begin
        for (j = i + 1; j < shadow_fill; j++) begin
          if (shadow_pri[j] < shadow_pri[i]) begin
            tv = shadow_val[i];
            tp = shadow_pri[i];
            shadow_val[i] = shadow_val[j];
            shadow_pri[i] = shadow_pri[j];
            shadow_val[j] = tv;
            shadow_pri[j] = tp;
          end
        end
      end
      hit = -1;
      for (i = 0; i < shadow_fill; i++) begin
        if (hit < 0 && shadow_pri[i] == cmd.item_priority) hit = i;
      end
      if (hit >= 0) begin
        res.removed_value = shadow_val[hit];
        res.found = 1'b1;
        for (i = hit; i + 1 < shadow_fill; i++) begin
          shadow_val[i] = shadow_val[i+1];
          shadow_pri[i] = shadow_pri[i+1];
        end
        shadow_fill--;
      end
    end
    res.entry_count = ENTRY_COUNT_W'(shadow_fill);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      shadow_fill = 0;
      result_q.delete();
    end else begin
      // result side first: a result at this edge belongs to an older command
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: unexpected result: value=%h found=%b refused=%b count=%0d",
                     $realtime, out_data.removed_value, out_data.found,
                     out_data.refused, out_data.entry_count);
        end else begin
          want = result_q.pop_front();
          bad = 1'b0;
          if (out_data.removed_value !== want.removed_value) bad = 1'b1;
          if (out_data.found !== want.found) bad = 1'b1;
          if (out_data.refused !== want.refused) bad = 1'b1;
          if (out_data.entry_count !== want.entry_count) bad = 1'b1;
          if (bad) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display("%0t: mismatch: expected value=%h found=%b refused=%b count=%0d, %s",
                       $realtime, want.removed_value, want.found, want.refused,
                       want.entry_count, "see actual below");
            if (errs <= MAX_REPORTS)
              $display("%0t:           actual value=%h found=%b refused=%b count=%0d",
                       $realtime, out_data.removed_value, out_data.found,
                       out_data.refused, out_data.entry_count);
          end
          if (want.found) hits++;
          if (want.refused) drops++;
        end
      end
      if (in_valid && in_ready) result_q.push_back(apply_command(in_data));
    end
    fail_count   <= errs;
    pending      <= result_q.size();
    found_seen   <= hits;
    refused_seen <= drops;
  end

endmodule

[sim/priority_table_remove_by_priority_tb.sv]
`timescale 1ns / 100ps

module priority_table_remove_by_priority_tb;
  import ptrbp_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int found_seen;
  int refused_seen;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_now = 1'b0;
  int   n_insert = 0;
  int   n_remove = 0;
  int   idle_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  priority_table_remove_by_priority uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  priority_table_remove_by_priority_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .found_seen   (found_seen),
    .refused_seen (refused_seen)
  );

  // Offers one command and returns once the transaction is accepted.
  task automatic send_cmd(input logic cmd, input logic [VALUE_W-1:0] val,
                          input logic [PRIO_W-1:0] prio);
    in_item_t item;
    item.command       = cmd;
    item.item_value    = val;
    item.item_priority = prio;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_INSERT) n_insert++;
    else n_remove++;
  endtask

  task automatic send_random(input int ins_pct, input int prio_max);
    logic cmd;
    logic [PRIO_W-1:0] prio;
    cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
    prio = PRIO_W'($urandom_range(0, prio_max));
    send_cmd(cmd, $urandom, prio);
  endtask

  // Sender pauses until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_now) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_now = 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: no transaction on either channel for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty remove, field extremes, miss, hits, full table
    send_cmd(CMD_REMOVE, 32'h0, 8'd0);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF, 8'd255);
    send_cmd(CMD_INSERT, 32'h8000_0000, 8'd0);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'd128);
    send_cmd(CMD_INSERT, 32'h0000_0000, 8'd1);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 8'd77);
    send_cmd(CMD_REMOVE, 32'h0, 8'd255);
    send_cmd(CMD_REMOVE, 32'h0, 8'd0);
    // fill up with repeated priorities, then one insert too many
    for (int k = 0; k < TABLE_DEPTH - 2; k++) send_cmd(CMD_INSERT, $urandom, PRIO_W'(k % 4));
    send_cmd(CMD_INSERT, 32'h1234_5678, 8'd200);
    send_cmd(CMD_REMOVE, 32'h0, 8'd2);
    send_cmd(CMD_REMOVE, 32'h0, 8'd1);
    drain_results();

    send_idle_pct = 20;
    recv_idle_pct = 10;
    for (int k = 0; k < 110; k++) send_random(70, 7);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 15;
    for (int k = 0; k < 100; k++) send_random(50, 15);
    drain_results();

    // insert-heavy: sits at full and refuses
    send_idle_pct = 30;
    recv_idle_pct = 0;
    for (int k = 0; k < 100; k++) send_random(85, 3);
    drain_results();

    // remove-heavy: empties the table and keeps removing
    send_idle_pct = 15;
    recv_idle_pct = 20;
    for (int k = 0; k < 100; k++) send_random(30, 7);
    drain_results();

    // long receiver hold-off while the sender keeps offering
    hold_now = 1'b1;
    for (int k = 0; k < 120; k++) begin
      if ($urandom_range(0, 1)) send_random(60, 255);
      else send_random(60, 3);
    end
    drain_results();

    // last stretch without idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 100; k++) send_random(55, 7);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d inserts, %0d removes.", n_insert + n_remove,
             n_insert, n_remove);
    $display("%0d removes found an entry, %0d inserts were refused on a full table.",
             found_seen, refused_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[priority_table_remove_by_priority.f]
+incdir+hdl
hdl/ptrbp_pkg.sv
hdl/ptrbp_ram.sv
hdl/priority_table_remove_by_priority.sv
sim/priority_table_remove_by_priority_checker.sv
sim/priority_table_remove_by_priority_tb.sv
